// ----- hw/rtl/trb_pkg.sv -----
// Shared types and constants of the trace ring buffer.
`default_nettype none
package trb_pkg;

    localparam int SEQ_W = 32;
    localparam int POS_W = 10;
    localparam int CNT_W = 11;
    localparam logic [SEQ_W-1:0] SEQ_NIL = '0;
    localparam logic [SEQ_W-1:0] SEQ_LAST = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [31:0] POS_MAX = 32'd1023;

    typedef enum logic [2:0] {
        ACT_CLEAR  = 3'd0,
        ACT_APPEND = 3'd1,
        ACT_AT     = 3'd2,
        ACT_POS    = 3'd3,
        ACT_TSC    = 3'd4,
        ACT_CTR    = 3'd5,
        ACT_COUNT  = 3'd6
    } t_action;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_HIDDEN    = 2'd2;
    localparam logic [1:0] ST_EXHAUSTED = 2'd3;

    typedef struct packed {
        logic load;
        logic append;
        logic sweep_start;
        logic clear_step;
        logic set_ok;
        logic count_step;
        logic pre_read;
        logic pre_check;
        logic walk_start;
        logic walk_step;
    } t_cmd;

    typedef struct packed {
        logic sweep_end;
        logic count_end;
        logic pre_go;
        logic walk_end;
    } t_sts;

endpackage
`default_nettype wire

// ----- hw/rtl/trb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module trb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/trb_dp.sv -----
// Datapath of the trace ring buffer: slot memory, walk pointers and result registers.
`default_nettype none
module trb_dp import trb_pkg::*; #(
    parameter int SLOTS = 1024,
    parameter int CPU_BITS = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_wdata,
    input  wire t_cmd              i_cmd,
    output t_sts                   o_sts,
    input  wire logic [2:0]        i_action,
    input  wire logic [POS_W-1:0]  i_position,
    input  wire logic [31:0]       i_query_seq,
    input  wire logic              i_counter_index,
    input  wire logic              i_entry_hidden,
    input  wire logic [7:0]        i_entry_cpu,
    input  wire logic [31:0]       i_entry_kclock,
    input  wire logic [63:0]       i_entry_tsc,
    input  wire logic [31:0]       i_entry_pmc_first,
    input  wire logic [31:0]       i_entry_pmc_second,
    output logic [1:0]             o_status,
    output logic [31:0]            o_found_seq,
    output logic [POS_W-1:0]       o_found_position,
    output logic [CNT_W-1:0]       o_entry_count,
    output logic [31:0]            o_out_kclock,
    output logic [63:0]            o_out_tsc,
    output logic [31:0]            o_out_pmc_first,
    output logic [31:0]            o_out_pmc_second,
    output logic signed [63:0]     o_delta
);
    localparam int IW = $clog2(SLOTS);
    localparam int WW = 1 + CPU_BITS + 32 + 64 + 32 + 32 + SEQ_W;
    localparam logic [SEQ_W-1:0] SLOTS_SEQ = SEQ_W'(SLOTS);

    logic              r_filter;
    logic [SEQ_W-1:0]  r_tail;
    logic [IW:0]       r_idx;
    logic              r_v;
    logic [SEQ_W-1:0]  r_dseq;
    logic [SEQ_W-1:0]  r_addr_seq;
    logic [SEQ_W-1:0]  r_bound;
    logic              r_phase;
    logic [IW:0]       r_p;
    logic [CNT_W-1:0]  r_cnt;
    logic [2:0]        r_action;
    logic [POS_W-1:0]  r_pos;
    logic [SEQ_W-1:0]  r_qseq;
    logic              r_cidx;
    logic [CPU_BITS-1:0] r_t_cpu;
    logic [63:0]       r_t_tsc;
    logic [31:0]       r_t_pmc;

    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic [WW-1:0]     ram_wdata;
    logic              ram_re;
    logic [IW-1:0]     ram_raddr;
    logic [WW-1:0]     ram_rdata;

    logic [SEQ_W-1:0]  n_seq;
    logic [SEQ_W-1:0]  n_bound;
    logic [SEQ_W-1:0]  rd_tag;
    logic [31:0]       rd_pmc_second;
    logic [31:0]       rd_pmc_first;
    logic [63:0]       rd_tsc;
    logic [31:0]       rd_kclock;
    logic [CPU_BITS-1:0] rd_cpu;
    logic              rd_hidden;
    logic              rd_shown;
    logic              vis;
    logic              issue_ok;
    logic              hit_final;
    logic              pre_match;
    logic [31:0]       pmc_sel;
    logic [31:0]       pmc_diff;

    trb_ram #(.WIDTH(WW), .DEPTH(SLOTS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign n_seq = r_tail + SEQ_W'(1);
    assign n_bound = (r_tail > SLOTS_SEQ) ? (r_tail - SLOTS_SEQ) : SEQ_NIL;
    assign rd_tag        = ram_rdata[SEQ_W-1:0];
    assign rd_pmc_second = ram_rdata[SEQ_W+:32];
    assign rd_pmc_first  = ram_rdata[SEQ_W+32+:32];
    assign rd_tsc        = ram_rdata[SEQ_W+64+:64];
    assign rd_kclock     = ram_rdata[SEQ_W+128+:32];
    assign rd_cpu        = ram_rdata[SEQ_W+160+:CPU_BITS];
    assign rd_hidden     = ram_rdata[SEQ_W+160+CPU_BITS];
    assign rd_shown  = !(r_filter && rd_hidden);
    assign vis       = r_v && (r_dseq != SEQ_NIL) && (rd_tag == r_dseq) && rd_shown;
    assign issue_ok  = r_addr_seq > r_bound;
    assign pre_match = (r_qseq != SEQ_NIL) && (rd_tag == r_qseq);
    assign pmc_sel   = r_cidx ? rd_pmc_second : rd_pmc_first;
    assign pmc_diff  = r_t_pmc - pmc_sel;

    always_comb begin
        hit_final = 1'b0;
        if (vis) begin
            unique case (r_action)
                ACT_AT:  hit_final = (r_pos == '0);
                ACT_POS: hit_final = (r_dseq == r_qseq);
                ACT_TSC: hit_final = r_phase && (rd_cpu == r_t_cpu);
                ACT_CTR: hit_final = r_phase;
                default: hit_final = 1'b0;
            endcase
        end
    end

    always_comb begin
        o_sts.sweep_end = r_idx[IW];
        o_sts.count_end = !r_v && r_idx[IW];
        o_sts.pre_go    = pre_match && rd_shown;
        o_sts.walk_end  = hit_final || (!r_v && !issue_ok);
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx[IW-1:0];
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = r_addr_seq[IW-1:0];
        if (i_cmd.clear_step && !r_idx[IW]) begin
            ram_we = 1'b1;
        end
        if (i_cmd.append && (r_tail != SEQ_LAST)) begin
            ram_we    = 1'b1;
            ram_waddr = n_seq[IW-1:0];
            ram_wdata = {i_entry_hidden, CPU_BITS'(i_entry_cpu), i_entry_kclock, i_entry_tsc,
                         i_entry_pmc_first, i_entry_pmc_second, n_seq};
        end
        if (i_cmd.count_step && !r_idx[IW]) begin
            ram_re    = 1'b1;
            ram_raddr = r_idx[IW-1:0];
        end
        if (i_cmd.pre_read) begin
            ram_re    = 1'b1;
            ram_raddr = r_qseq[IW-1:0];
        end
        if (i_cmd.walk_step && issue_ok) begin
            ram_re = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter <= 1'b0;
            r_tail   <= SEQ_NIL;
            r_idx    <= '0;
            r_v      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_filter <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_action         <= i_action;
                r_pos            <= i_position;
                r_qseq           <= i_query_seq;
                r_cidx           <= i_counter_index;
                o_status         <= ST_NOT_FOUND;
                o_found_seq      <= '0;
                o_found_position <= '0;
                o_entry_count    <= '0;
                o_out_kclock     <= '0;
                o_out_tsc        <= '0;
                o_out_pmc_first  <= '0;
                o_out_pmc_second <= '0;
                o_delta          <= '0;
            end
            if (i_cmd.append) begin
                if (r_tail == SEQ_LAST) begin
                    o_status <= ST_EXHAUSTED;
                end else begin
                    r_tail      <= n_seq;
                    o_found_seq <= n_seq;
                    o_status    <= ST_OK;
                end
            end
            if (i_cmd.sweep_start) begin
                r_idx <= '0;
                r_v   <= 1'b0;
                r_cnt <= '0;
            end
            if (i_cmd.clear_step) begin
                r_tail <= SEQ_NIL;
                if (!r_idx[IW]) begin
                    r_idx <= r_idx + (IW+1)'(1);
                end
            end
            if (i_cmd.set_ok) begin
                o_status <= ST_OK;
            end
            if (i_cmd.count_step) begin
                r_v <= !r_idx[IW];
                if (!r_idx[IW]) begin
                    r_idx <= r_idx + (IW+1)'(1);
                end
                if (r_v && (rd_tag != SEQ_NIL) && rd_shown && (r_cnt != CNT_MAX)) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                if (!r_v && r_idx[IW]) begin
                    o_entry_count <= r_cnt;
                    o_status      <= ST_OK;
                end
            end
            if (i_cmd.pre_check && pre_match && !rd_shown) begin
                o_status    <= ST_HIDDEN;
                o_found_seq <= r_qseq;
            end
            if (i_cmd.walk_start || i_cmd.pre_check) begin
                r_addr_seq <= r_tail;
                r_bound    <= n_bound;
                r_v        <= 1'b0;
                r_phase    <= 1'b0;
                r_p        <= '0;
            end
            if (i_cmd.walk_step) begin
                r_v <= issue_ok;
                if (issue_ok) begin
                    r_dseq     <= r_addr_seq;
                    r_addr_seq <= r_addr_seq - SEQ_W'(1);
                end
                if (vis) begin
                    if (r_action == ACT_POS) begin
                        if (r_dseq == r_qseq) begin
                            if (32'(r_p) <= POS_MAX) begin
                                o_status         <= ST_OK;
                                o_found_seq      <= r_qseq;
                                o_found_position <= POS_W'(r_p);
                            end
                        end else begin
                            r_p <= r_p + (IW+1)'(1);
                        end
                    end else if (!r_phase) begin
                        if (r_pos == '0) begin
                            if (r_action == ACT_AT) begin
                                o_status         <= ST_OK;
                                o_found_seq      <= r_dseq;
                                o_out_kclock     <= rd_kclock;
                                o_out_tsc        <= rd_tsc;
                                o_out_pmc_first  <= rd_pmc_first;
                                o_out_pmc_second <= rd_pmc_second;
                            end
                            r_phase <= 1'b1;
                            r_t_cpu <= rd_cpu;
                            r_t_tsc <= rd_tsc;
                            r_t_pmc <= pmc_sel;
                        end else begin
                            r_pos <= r_pos - POS_W'(1);
                        end
                    end else if (hit_final) begin
                        o_status <= ST_OK;
                        if (r_action == ACT_TSC) begin
                            o_delta <= r_t_tsc - rd_tsc;
                        end else begin
                            o_delta <= {{32{pmc_diff[31]}}, pmc_diff};
                        end
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/trb_ctrl.sv -----
// Controller state machine of the trace ring buffer.
`default_nettype none
module trb_ctrl import trb_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    input  wire logic [2:0] i_action,
    output t_cmd            o_cmd,
    input  wire t_sts       i_sts
);
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_COUNT,
        S_PRE,
        S_CHK,
        S_WALK,
        S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_clr_resp;
    logic   accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_RESP);
    assign accept      = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RESP;
                    unique case (i_action)
                        ACT_CLEAR: begin
                            o_cmd.sweep_start = 1'b1;
                            n_state           = S_CLEAR;
                        end
                        ACT_APPEND: o_cmd.append = 1'b1;
                        ACT_AT, ACT_TSC, ACT_CTR: begin
                            o_cmd.walk_start = 1'b1;
                            n_state          = S_WALK;
                        end
                        ACT_POS: n_state = S_PRE;
                        ACT_COUNT: begin
                            o_cmd.sweep_start = 1'b1;
                            n_state           = S_COUNT;
                        end
                        default: n_state = S_RESP;
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.sweep_end) begin
                    o_cmd.set_ok = r_clr_resp;
                    n_state      = r_clr_resp ? S_RESP : S_IDLE;
                end
            end
            S_COUNT: begin
                o_cmd.count_step = 1'b1;
                if (i_sts.count_end) begin
                    n_state = S_RESP;
                end
            end
            S_PRE: begin
                o_cmd.pre_read = 1'b1;
                n_state        = S_CHK;
            end
            S_CHK: begin
                o_cmd.pre_check = 1'b1;
                n_state         = i_sts.pre_go ? S_WALK : S_RESP;
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_sts.walk_end) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_resp <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_clr_resp <= 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/trace_ring_buffer.sv -----
// Top level of the sequence-numbered trace ring buffer.
// The input channel (i_valid/o_ready) carries one command transaction: clear, append,
// entry at position, position of sequence, cycle counter delta, counter delta or count.
// The output channel (o_valid/i_ready) returns exactly one result transaction for each.
// One command is worked on at a time; o_ready is high only while the block is idle.
// Append and the unused code answer in the cycle after acceptance.
// Clear sweeps every slot tag, one slot a cycle.
// Count reads every slot.
// Position queries and both deltas walk back from the newest entry, one slot a cycle
// through the read port of the slot memory; a position-of-sequence lookup first reads
// the queried slot for its tag check.
// After reset the block runs the same sweep as clear before it raises o_ready; no result
// is produced for it. Configuration writes are taken at any time.
// A result holds on the outputs until i_ready is seen; the block takes no new command
// while the receiver stalls.
`default_nettype none
module trace_ring_buffer import trb_pkg::*; #(
    parameter int SLOTS = 1024,
    parameter int CPU_BITS = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_wdata,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [2:0]        i_action,
    input  wire logic [POS_W-1:0]  i_position,
    input  wire logic [31:0]       i_query_seq,
    input  wire logic              i_counter_index,
    input  wire logic              i_entry_hidden,
    input  wire logic [7:0]        i_entry_cpu,
    input  wire logic [31:0]       i_entry_kclock,
    input  wire logic [63:0]       i_entry_tsc,
    input  wire logic [31:0]       i_entry_pmc_first,
    input  wire logic [31:0]       i_entry_pmc_second,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [1:0]             o_status,
    output logic [31:0]            o_found_seq,
    output logic [POS_W-1:0]       o_found_position,
    output logic [CNT_W-1:0]       o_entry_count,
    output logic [31:0]            o_out_kclock,
    output logic [63:0]            o_out_tsc,
    output logic [31:0]            o_out_pmc_first,
    output logic [31:0]            o_out_pmc_second,
    output logic signed [63:0]     o_delta
);
    t_cmd cmd;
    t_sts sts;

    trb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .o_out_valid(o_valid),
        .i_out_ready(i_ready),
        .i_action   (i_action),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    trb_dp #(.SLOTS(SLOTS), .CPU_BITS(CPU_BITS)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_action          (i_action),
        .i_position        (i_position),
        .i_query_seq       (i_query_seq),
        .i_counter_index   (i_counter_index),
        .i_entry_hidden    (i_entry_hidden),
        .i_entry_cpu       (i_entry_cpu),
        .i_entry_kclock    (i_entry_kclock),
        .i_entry_tsc       (i_entry_tsc),
        .i_entry_pmc_first (i_entry_pmc_first),
        .i_entry_pmc_second(i_entry_pmc_second),
        .o_status          (o_status),
        .o_found_seq       (o_found_seq),
        .o_found_position  (o_found_position),
        .o_entry_count     (o_entry_count),
        .o_out_kclock      (o_out_kclock),
        .o_out_tsc         (o_out_tsc),
        .o_out_pmc_first   (o_out_pmc_first),
        .o_out_pmc_second  (o_out_pmc_second),
        .o_delta           (o_delta)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("result pending while a new command is accepted");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_ready)
        else $error("activity right after reset");

    a_hidden_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_HIDDEN)) |-> (o_found_seq != SEQ_NIL))
        else $error("hidden status without a sequence number");

    a_exhausted_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_EXHAUSTED)) |-> (o_found_seq == SEQ_NIL))
        else $error("refused append reports a sequence number");
endmodule
`default_nettype wire
